### hw/rtl/miq_pkg.sv
// Package for the middle-insert queue: item word types, operation and status codes,
// controller states and the command and status structs between controller and datapath.
// Depends on nothing.
`default_nettype none

package miq_pkg;

    localparam int ITEM_BITS        = 32;
    localparam int COUNT_BITS       = 11;
    localparam int CAPACITY_DEFAULT = 1024;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_INSERT_MID = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_READ_FRONT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                  operation;
        logic [ITEM_BITS-1:0] item;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [ITEM_BITS-1:0]  front_item;
        logic [COUNT_BITS-1:0] count;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_EXEC     = 3'd1,
        S_REB_RD   = 3'd2,
        S_REB_WR   = 3'd3,
        S_FRONT_RD = 3'd4,
        S_RESP     = 3'd5
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic reb_rd;
        logic reb_wr;
        logic front_rd;
    } cmd_t;

    typedef struct packed {
        logic reb_needed;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/miq_ctrl.sv
// Controller state machine of the middle-insert queue.
// Depends on miq_pkg for the state enum and the command and status structs.
`default_nettype none

module miq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire miq_pkg::dp_status_t dp_status,
    output logic                    busy,
    output logic                    done,
    output miq_pkg::cmd_t           cmd
);

    miq_pkg::state_t state_reg;
    miq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= miq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            miq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = miq_pkg::S_EXEC;
                end
            end
            miq_pkg::S_EXEC:
            begin
                if (dp_status.reb_needed)
                begin
                    state_next = miq_pkg::S_REB_RD;
                end
                else
                begin
                    state_next = miq_pkg::S_FRONT_RD;
                end
            end
            miq_pkg::S_REB_RD:   state_next = miq_pkg::S_REB_WR;
            miq_pkg::S_REB_WR:   state_next = miq_pkg::S_FRONT_RD;
            miq_pkg::S_FRONT_RD: state_next = miq_pkg::S_RESP;
            miq_pkg::S_RESP:     state_next = miq_pkg::S_IDLE;
            default:             state_next = miq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        busy         = 1'b1;
        done         = 1'b0;
        case (state_reg)
            miq_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            miq_pkg::S_EXEC:     cmd.exec     = 1'b1;
            miq_pkg::S_REB_RD:   cmd.reb_rd   = 1'b1;
            miq_pkg::S_REB_WR:   cmd.reb_wr   = 1'b1;
            miq_pkg::S_FRONT_RD: cmd.front_rd = 1'b1;
            miq_pkg::S_RESP:     done         = 1'b1;
            default:             busy         = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/miq_dpath.sv
// Datapath of the middle-insert queue: both ring memories, their pointers and the count.
// Depends on miq_pkg for the item types, the codes and the command and status structs.
`default_nettype none

module miq_dpath #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire miq_pkg::req_t        req,
    input  wire miq_pkg::cmd_t        cmd,
    output miq_pkg::dp_status_t       dp_status,
    output miq_pkg::result_t          result
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    logic [miq_pkg::ITEM_BITS-1:0] front_ring [CAPACITY];
    logic [miq_pkg::ITEM_BITS-1:0] back_ring  [CAPACITY];

    miq_pkg::op_t                  op_reg;
    logic [miq_pkg::ITEM_BITS-1:0] word_reg;
    logic [miq_pkg::ITEM_BITS-1:0] back_rd_reg;
    logic [miq_pkg::ITEM_BITS-1:0] front_rd_reg;
    miq_pkg::status_t              status_reg, status_next;

    logic [PTR_W-1:0] fh_reg, fh_next;
    logic [PTR_W-1:0] ft_reg, ft_next;
    logic [PTR_W-1:0] bh_reg, bh_next;
    logic [PTR_W-1:0] bt_reg, bt_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [PTR_W-1:0] fh_inc, ft_inc, bh_inc, bh_dec, bt_inc;
    logic             full, empty;

    logic                          front_we, back_we;
    logic [PTR_W-1:0]              back_waddr;
    logic [miq_pkg::ITEM_BITS-1:0] front_wdata;

    logic [CNT_W+miq_pkg::COUNT_BITS-1:0] count_wide;

    assign fh_inc = (fh_reg == LAST_IDX) ? '0 : fh_reg + 1'b1;
    assign ft_inc = (ft_reg == LAST_IDX) ? '0 : ft_reg + 1'b1;
    assign bh_inc = (bh_reg == LAST_IDX) ? '0 : bh_reg + 1'b1;
    assign bt_inc = (bt_reg == LAST_IDX) ? '0 : bt_reg + 1'b1;
    assign bh_dec = (bh_reg == '0) ? LAST_IDX : bh_reg - 1'b1;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // Push at the back and pop at the front leave the count odd exactly when it was even.
    assign dp_status.reb_needed = !count_reg[0] &&
        (((op_reg == miq_pkg::OP_PUSH_BACK) && !full) ||
         ((op_reg == miq_pkg::OP_POP_FRONT) && !empty));

    always_comb
    begin
        fh_next     = fh_reg;
        ft_next     = ft_reg;
        bh_next     = bh_reg;
        bt_next     = bt_reg;
        count_next  = count_reg;
        status_next = status_reg;
        front_we    = 1'b0;
        back_we     = 1'b0;
        back_waddr  = bt_reg;
        front_wdata = word_reg;
        if (cmd.exec)
        begin
            status_next = miq_pkg::ST_OK;
            case (op_reg)
                miq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = miq_pkg::ST_FULL;
                    end
                    else
                    begin
                        back_we    = 1'b1;
                        back_waddr = bt_reg;
                        bt_next    = bt_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                miq_pkg::OP_INSERT_MID:
                begin
                    if (full)
                    begin
                        status_next = miq_pkg::ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (!count_reg[0])
                        begin
                            front_we = 1'b1;
                            ft_next  = ft_inc;
                        end
                        else
                        begin
                            back_we    = 1'b1;
                            back_waddr = bh_dec;
                            bh_next    = bh_dec;
                        end
                    end
                end
                miq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = miq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        fh_next    = fh_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                miq_pkg::OP_READ_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = miq_pkg::ST_EMPTY;
                    end
                end
                default: status_next = miq_pkg::ST_OK;
            endcase
        end
        else if (cmd.reb_wr)
        begin
            front_we    = 1'b1;
            front_wdata = back_rd_reg;
            ft_next     = ft_inc;
            bh_next     = bh_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg     <= '0;
            ft_reg     <= '0;
            bh_reg     <= '0;
            bt_reg     <= '0;
            count_reg  <= '0;
            status_reg <= miq_pkg::ST_OK;
        end
        else
        begin
            fh_reg     <= fh_next;
            ft_reg     <= ft_next;
            bh_reg     <= bh_next;
            bt_reg     <= bt_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req.operation;
            word_reg <= req.item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_we)
        begin
            front_ring[ft_reg] <= front_wdata;
        end
        if (cmd.front_rd)
        begin
            front_rd_reg <= front_ring[fh_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            back_ring[back_waddr] <= word_reg;
        end
        if (cmd.reb_rd)
        begin
            back_rd_reg <= back_ring[bh_reg];
        end
    end

    assign count_wide        = {{miq_pkg::COUNT_BITS{1'b0}}, count_reg};
    assign result.status     = status_reg;
    assign result.front_item = empty ? '0 : front_rd_reg;
    assign result.count      = count_wide[miq_pkg::COUNT_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/middle_insert_queue.sv
// Top level of the middle-insert queue: joins the controller and the datapath.
// Depends on miq_pkg, miq_ctrl and miq_dpath.
//
//   channel   ports               direction   handshake
//   request   start, busy, req    in          taken at an edge with start high, busy low
//   result    done, result        out         shown one cycle with done high, no stall
//
// When no rebalance is due, an item that is accepted goes through the execute step, the
// front-ring read and the result cycle. When one is due, the rebalance comes after the
// execute step: it reads the head of the back ring through its registered read port and
// then writes the tail of the front ring, and the front word is then read through the
// front ring's port. After the result cycle the controller is idle with busy low, and
// the next item can be taken there, so a new item is never taken before the last one's
// result has been shown. The receiver cannot stall, so the result is shown for exactly
// one cycle. Reset clears the pointers, the count and the controller; the ring memories
// are not cleared, since a word is only shown once its entry has been written.
`default_nettype none

module middle_insert_queue #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire miq_pkg::req_t    req,
    output logic                  busy,
    output logic                  done,
    output miq_pkg::result_t      result
);

    // Commands from the controller, one per step of the sequence.
    miq_pkg::cmd_t       cmd;
    // The datapath tells the controller whether the back ring's head must move over.
    miq_pkg::dp_status_t dp_status;

    miq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .busy      (busy),
        .done      (done),
        .cmd       (cmd)
    );

    miq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .dp_status (dp_status),
        .result    (result)
    );

endmodule

`default_nettype wire

### hw/rtl/miq_checker.sv
// Port-level checker for the middle-insert queue, bound to the top level.
// Depends on miq_pkg for the result struct and the status codes.
`default_nettype none

module miq_checker #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEFAULT
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire miq_pkg::result_t result
);

    localparam logic [miq_pkg::COUNT_BITS-1:0] FULL_COUNT =
        miq_pkg::COUNT_BITS'(CAPACITY);

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while the block is idle");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted item did not start a sequence");

    a_empty_front_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.count == '0) |-> (result.front_item == '0))
        else $error("front item not zero on an empty queue");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == miq_pkg::ST_FULL) |-> (result.count == FULL_COUNT))
        else $error("full status without a full count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == miq_pkg::ST_EMPTY) |-> (result.count == '0))
        else $error("empty status with items held");

endmodule

bind middle_insert_queue miq_checker #(
    .CAPACITY (CAPACITY)
) u_miq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
